// ----- sv/tagged_varint_array_encoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tagged varint array encoder
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TAGGED_VARINT_ARRAY_ENCODER_CORE_MACROS_SVH
`define TAGGED_VARINT_ARRAY_ENCODER_CORE_MACROS_SVH

// Same-cycle implication or plain condition.
`define TVAE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define TVAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tvae_pkg.sv -----
// ----------------------------------------------------------------------------
// tvae_pkg
// Types, codes and helper functions of the tagged varint array encoder.
// ----------------------------------------------------------------------------
package tvae_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int GROUP_SIZE  = 4;

    typedef enum logic
    {
        CMD_START   = 1'b0,
        CMD_ELEMENT = 1'b1
    } cmd_t;

    // Size tag codes
    localparam logic [1:0] TAG_ZERO = 2'd0;
    localparam logic [1:0] TAG_ONE  = 2'd1;
    localparam logic [1:0] TAG_TWO  = 2'd2;
    localparam logic [1:0] TAG_FOUR = 2'd3;

    typedef enum logic
    {
        BK_IDLE,
        BK_BODY
    } back_state_t;

    // One unit of work for the byte serializer: a head byte (count or tag
    // byte) followed by the bytes of every value whose tag is nonzero.
    typedef struct packed
    {
        logic                              end_flag;
        logic [7:0]                        head;
        logic [GROUP_SIZE-1:0][1:0]        tags;
        logic [GROUP_SIZE-1:0][31:0]       vals;
    } job_t;

    typedef struct packed
    {
        logic       found;
        logic [1:0] idx;
    } pick_t;

    function automatic logic [1:0] size_tag(input logic [31:0] v);
        logic [31:0] mag;
        logic [1:0]  tag;
        mag = v[31] ? (~v + 32'd1) : v;
        if (mag == 32'd0)
            tag = TAG_ZERO;
        else if (mag[31:7] == 25'd0)
            tag = TAG_ONE;
        else if (mag[31:15] == 17'd0)
            tag = TAG_TWO;
        else
            tag = TAG_FOUR;
        return tag;
    endfunction

    // True when byte idx is the final byte of a value with this tag.
    function automatic logic last_byte(input logic [1:0] tag, input logic [1:0] idx);
        logic res;
        unique case (tag)
            TAG_ONE:  res = (idx == 2'd0);
            TAG_TWO:  res = (idx == 2'd1);
            TAG_FOUR: res = (idx == 2'd3);
            TAG_ZERO: res = (idx == 2'd3);
        endcase
        return res;
    endfunction

    // Lowest set bit of a four-bit mask.
    function automatic pick_t pick_first(input logic [GROUP_SIZE-1:0] mask);
        pick_t res;
        res = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                res.found = 1'b1;
                res.idx   = 2'(i);
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/tvae_front.sv -----
// ----------------------------------------------------------------------------
// tvae_front
// Accepts start and element transactions, tracks the open array and the
// current group, and pushes a job for every count byte or finished group.
// ----------------------------------------------------------------------------
module tvae_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic [7:0]          in_count,
    input  logic signed [31:0]  in_value,
    input  logic                queue_full,
    output logic                job_push,
    output tvae_pkg::job_t      job
);

    logic [7:0] array_length_reg,   array_length_next;
    logic [7:0] elements_taken_reg, elements_taken_next;
    logic [1:0] group_fill_reg,     group_fill_next;
    logic       array_open_reg,     array_open_next;

    logic [31:0] group_vals_reg [tvae_pkg::GROUP_SIZE];
    logic [1:0]  group_tags_reg [tvae_pkg::GROUP_SIZE];

    logic       accept;
    logic       is_start;
    logic       elem_take;
    logic [7:0] taken_inc;
    logic       done;
    logic [1:0] new_tag;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign is_start  = (tvae_pkg::cmd_t'(in_cmd) == tvae_pkg::CMD_START);
    assign elem_take = accept && !is_start && array_open_reg;
    assign taken_inc = elements_taken_reg + 8'd1;
    assign done      = (taken_inc == array_length_reg);
    assign new_tag   = tvae_pkg::size_tag(in_value);

    // Merge the arriving value into the group; positions past it read as zero tags.
    always_comb
    begin
        job = '0;
        for (int i = 0; i < tvae_pkg::GROUP_SIZE; i++)
        begin
            if (2'(i) == group_fill_reg)
            begin
                job.vals[i] = in_value;
                job.tags[i] = new_tag;
            end
            else if (2'(i) < group_fill_reg)
            begin
                job.vals[i] = group_vals_reg[i];
                job.tags[i] = group_tags_reg[i];
            end
            else
            begin
                job.vals[i] = group_vals_reg[i];
                job.tags[i] = tvae_pkg::TAG_ZERO;
            end
        end
        if (is_start)
        begin
            job.tags     = '0;
            job.head     = in_count;
            job.end_flag = (in_count == 8'd0);
        end
        else
        begin
            job.head     = {job.tags[0], job.tags[1], job.tags[2], job.tags[3]};
            job.end_flag = done;
        end
    end

    always_comb
    begin
        array_length_next   = array_length_reg;
        elements_taken_next = elements_taken_reg;
        group_fill_next     = group_fill_reg;
        array_open_next     = array_open_reg;
        job_push            = 1'b0;
        if (accept && is_start)
        begin
            array_length_next   = in_count;
            elements_taken_next = 8'd0;
            group_fill_next     = 2'd0;
            array_open_next     = (in_count != 8'd0);
            job_push            = 1'b1;
        end
        else if (elem_take)
        begin
            elements_taken_next = taken_inc;
            group_fill_next     = group_fill_reg + 2'd1;
            if (done || group_fill_reg == 2'(tvae_pkg::GROUP_SIZE - 1))
            begin
                job_push        = 1'b1;
                group_fill_next = 2'd0;
            end
            if (done)
                array_open_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_length_reg   <= 8'd0;
            elements_taken_reg <= 8'd0;
            group_fill_reg     <= 2'd0;
            array_open_reg     <= 1'b0;
        end
        else
        begin
            array_length_reg   <= array_length_next;
            elements_taken_reg <= elements_taken_next;
            group_fill_reg     <= group_fill_next;
            array_open_reg     <= array_open_next;
        end
    end

    // Group store: payload only
    always_ff @(posedge clk)
    begin
        if (elem_take)
        begin
            group_vals_reg[group_fill_reg] <= in_value;
            group_tags_reg[group_fill_reg] <= new_tag;
        end
    end

endmodule

// ----- sv/tvae_queue.sv -----
// ----------------------------------------------------------------------------
// tvae_queue
// Short job FIFO between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
`include "tagged_varint_array_encoder_core_macros.svh"

module tvae_queue
#(
    parameter int DEPTH = tvae_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tvae_pkg::job_t  job_in,
    output logic            full,
    input  logic            pop,
    output tvae_pkg::job_t  job_out,
    output logic            empty
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    tvae_pkg::job_t entries [DEPTH];

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + COUNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= job_in;
    end

    `TVAE_ASSERT(a_count_bound, count_reg <= COUNT_W'(DEPTH), "queue count past depth")
    `TVAE_ASSERT_NEXT(a_push_only_with_room, push && !pop, count_reg != '0, "push lost")

endmodule

// ----- sv/tvae_back.sv -----
// ----------------------------------------------------------------------------
// tvae_back
// Byte serializer: emits the head byte of a job, then the little-endian
// bytes of each value with a nonzero tag, one byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "tagged_varint_array_encoder_core_macros.svh"

module tvae_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  tvae_pkg::job_t  job_in,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_end
);

    tvae_pkg::back_state_t state_reg, state_next;
    tvae_pkg::job_t        job_reg,   job_next;

    logic [1:0] k_reg,         k_next;
    logic [1:0] b_reg,         b_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_last_reg,  out_last_next;
    logic       out_end_reg,   out_end_next;

    logic                              advance;
    logic [tvae_pkg::GROUP_SIZE-1:0]   nz_q;
    logic [tvae_pkg::GROUP_SIZE-1:0]   nz_r;
    tvae_pkg::pick_t                   first_q;
    tvae_pkg::pick_t                   next_r;
    logic [31:0]                       cur_val;
    logic                              val_done;
    logic                              final_byte;

    assign advance = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < tvae_pkg::GROUP_SIZE; i++)
        begin
            nz_q[i] = (job_in.tags[i]  != tvae_pkg::TAG_ZERO);
            nz_r[i] = (job_reg.tags[i] != tvae_pkg::TAG_ZERO);
        end
    end

    assign first_q    = tvae_pkg::pick_first(nz_q);
    assign next_r     = tvae_pkg::pick_first(nz_r & 4'(4'b1110 << k_reg));
    assign cur_val    = job_reg.vals[k_reg];
    assign val_done   = tvae_pkg::last_byte(job_reg.tags[k_reg], b_reg);
    assign final_byte = val_done && !next_r.found;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tvae_pkg::BK_IDLE:
            begin
                if (advance && !empty && first_q.found)
                    state_next = tvae_pkg::BK_BODY;
            end
            tvae_pkg::BK_BODY:
            begin
                if (advance && final_byte)
                    state_next = tvae_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        job_next       = job_reg;
        k_next         = k_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (advance)
            out_valid_next = 1'b0;
        unique case (state_reg)
            tvae_pkg::BK_IDLE:
            begin
                if (advance && !empty)
                begin
                    pop            = 1'b1;
                    job_next       = job_in;
                    k_next         = first_q.idx;
                    b_next         = 2'd0;
                    out_valid_next = 1'b1;
                    out_byte_next  = job_in.head;
                    out_last_next  = !first_q.found;
                    out_end_next   = !first_q.found && job_in.end_flag;
                end
            end
            tvae_pkg::BK_BODY:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_val[{b_reg, 3'b000} +: 8];
                    out_last_next  = final_byte;
                    out_end_next   = final_byte && job_reg.end_flag;
                    if (val_done)
                    begin
                        k_next = next_r.idx;
                        b_next = 2'd0;
                    end
                    else
                        b_next = b_reg + 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvae_pkg::BK_IDLE;
            k_reg         <= 2'd0;
            b_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            b_reg         <= b_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_end_reg   <= out_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_end   = out_end_reg;

    `TVAE_ASSERT(a_pop_nonempty, pop |-> !empty, "pop from empty queue")
    `TVAE_ASSERT(a_end_on_last, out_valid_reg |-> (!out_end_reg || out_last_reg), "end without last")
    `TVAE_ASSERT(a_body_on_nonzero, (state_reg == tvae_pkg::BK_BODY) |-> nz_r[k_reg], "zero-tag value")

endmodule

// ----- sv/tagged_varint_array_encoder_core.sv -----
// ----------------------------------------------------------------------------
// tagged_varint_array_encoder_core
// Group varint encoder with 2-bit size tags for arrays of signed 32-bit words.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata              tuser          tlast
//  s_*       in   count, value       cmd            -
//  m_*       out  out_byte           end_of_array   last_of_run
//
//  The input side takes one transaction per cycle while the job queue has room.
//  The output port moves one byte per cycle while m_tready is high: a start
//  emits 1 byte, a group 1 + its value bytes, up to 17; this port sets the rate.
//  Elements that do not close a group emit no output bytes.
//  rst_n clears the array state, the job queue and the output valid, last and end flags.
//  A stalled output holds its byte; the queue lets intake continue meanwhile.
// ----------------------------------------------------------------------------
module tagged_varint_array_encoder_core
#(
    parameter int QUEUE_DEPTH = tvae_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] count, [39:8] value
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser    // [0] end_of_array
);

    logic           job_push;
    logic           queue_full;
    logic           queue_empty;
    logic           job_pop;
    tvae_pkg::job_t front_job;
    tvae_pkg::job_t queue_job;

    tvae_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_count   (s_tdata[7:0]),
        .in_value   (s_tdata[39:8]),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (front_job)
    );

    tvae_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (front_job),
        .full    (queue_full),
        .pop     (job_pop),
        .job_out (queue_job),
        .empty   (queue_empty)
    );

    tvae_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .job_in    (queue_job),
        .pop       (job_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_end   (m_tuser)
    );

endmodule
